>>> sv/asf_pkg.sv
// Shared types, constants and register indexes for the alignment site filter.
package asf_pkg;

    localparam int NUM_BASES    = 4;
    localparam int BASE_CNT_W   = 11;
    localparam int TOTAL_W      = BASE_CNT_W + 2;
    localparam int COUNT_WIDTH  = 32;
    localparam int CODE_W       = 3;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 11;
    localparam int BASE_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REQUIRED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT_ONLY = CFG_IDX_W'(1);

    typedef logic [BASE_CNT_W-1:0]  t_base_cnt;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [BASE_IDX_W-1:0]  t_base_idx;

    typedef enum logic [1:0] {
        ST_DROP_MISSING  = 2'd0,
        ST_DROP_CONSTANT = 2'd1,
        ST_KEPT_CONSTANT = 2'd2,
        ST_KEPT_VARIANT  = 2'd3
    } t_site_status;

    // Outcome of one site end, handed from the classifier to the counters.
    typedef struct packed {
        t_site_status status;
        logic         inc_site;
        logic         inc_variant;
        logic         inc_const;
        t_base_idx    const_base;
    } t_site_result;

    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + t_count'(1);
    endfunction

endpackage

>>> sv/asf_classify.sv
// Per-base tally update and end-of-site classification.
module asf_classify (
    input  logic [asf_pkg::CODE_W-1:0]     i_code,
    input  logic                           i_last,
    input  asf_pkg::t_base_cnt             i_counts [asf_pkg::NUM_BASES],
    input  logic [asf_pkg::BASE_CNT_W-1:0] i_min_required,
    input  logic                           i_variant_only,
    output asf_pkg::t_base_cnt             o_counts [asf_pkg::NUM_BASES],
    output asf_pkg::t_site_result          o_result
);

    asf_pkg::t_base_cnt              w_upd [asf_pkg::NUM_BASES];
    logic [asf_pkg::TOTAL_W-1:0]     w_total;
    logic [asf_pkg::NUM_BASES-1:0]   w_present;
    logic                            w_missing;
    logic                            w_single;
    asf_pkg::t_base_idx              w_cbase;

    always_comb begin
        w_total   = '0;
        w_present = '0;
        w_cbase   = '0;
        for (int i = 0; i < asf_pkg::NUM_BASES; i++) begin
            // Count the incoming base first, holding at the tally maximum.
            if (i_code == asf_pkg::CODE_W'(i) && i_counts[i] != '1) begin
                w_upd[i] = i_counts[i] + asf_pkg::t_base_cnt'(1);
            end else begin
                w_upd[i] = i_counts[i];
            end
            w_present[i] = (w_upd[i] != '0);
            w_total      = w_total + asf_pkg::TOTAL_W'(w_upd[i]);
            if (w_present[i]) begin
                w_cbase = asf_pkg::t_base_idx'(i);
            end
        end
        w_missing = (w_total == '0) || (w_total < asf_pkg::TOTAL_W'(i_min_required));
        w_single  = $onehot(w_present);
    end

    always_comb begin
        for (int i = 0; i < asf_pkg::NUM_BASES; i++) begin
            // Clear the tallies once the site is closed.
            o_counts[i] = i_last ? '0 : w_upd[i];
        end
        o_result.const_base  = w_cbase;
        o_result.inc_site    = 1'b0;
        o_result.inc_variant = 1'b0;
        o_result.inc_const   = 1'b0;
        if (w_missing) begin
            o_result.status = asf_pkg::ST_DROP_MISSING;
        end else if (w_single && i_variant_only) begin
            o_result.status    = asf_pkg::ST_DROP_CONSTANT;
            o_result.inc_site  = 1'b1;
            o_result.inc_const = 1'b1;
        end else if (!w_single) begin
            o_result.status      = asf_pkg::ST_KEPT_VARIANT;
            o_result.inc_site    = 1'b1;
            o_result.inc_variant = 1'b1;
        end else begin
            o_result.status   = asf_pkg::ST_KEPT_CONSTANT;
            o_result.inc_site = 1'b1;
        end
    end

endmodule

>>> sv/alignment_site_filter_core.sv
// Alignment site filter: tallies bases per site and classifies each site at its end.
//
// Input channel: one base per transfer (i_in_valid, o_in_stall, i_base_code,
// i_last_sample). A transfer with i_last_sample high closes the site and
// yields one result; other transfers yield none.
// Output channel: o_out_valid with i_out_stall; a result carries the site
// status and the running site, variant and constant-base counters.
// Configuration: i_cfg_valid/o_cfg_ready write min_required (index 0) and
// variant_only (index 1); o_cfg_ready is always high. Write only while idle.
// Throughput: one base per cycle, save where a held result stalls a site-closing
// base. A base waits in the input register and is tallied as it leaves; a
// site-closing base loads its result into the output register as it leaves.
// A held result stalls only site-closing bases in the input register, and
// through it the input channel.
// Reset (synchronous, active low) clears the tallies, all counters, both
// configuration registers and both valid flags.
module alignment_site_filter_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [asf_pkg::CODE_W-1:0]     i_base_code,
    input  logic                           i_last_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_site_status,
    output logic [31:0]                    o_site_total,
    output logic [31:0]                    o_variant_total,
    output logic [31:0]                    o_const_a_total,
    output logic [31:0]                    o_const_c_total,
    output logic [31:0]                    o_const_g_total,
    output logic [31:0]                    o_const_t_total,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [asf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [asf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic                           r_in_valid;
    logic [asf_pkg::CODE_W-1:0]     r_code;
    logic                           r_last;
    logic                           r_out_valid;
    asf_pkg::t_site_status          r_status;
    logic [asf_pkg::BASE_CNT_W-1:0] r_min_required;
    logic                           r_variant_only;
    asf_pkg::t_base_cnt             r_counts [asf_pkg::NUM_BASES];
    asf_pkg::t_count                r_sites_passed;
    asf_pkg::t_count                r_variant_sites;
    asf_pkg::t_count                r_const_counts [asf_pkg::NUM_BASES];

    asf_pkg::t_base_cnt             n_counts [asf_pkg::NUM_BASES];
    asf_pkg::t_site_result          w_result;
    logic                           w_out_blocked;
    logic                           w_advance;
    logic                           w_close;

    asf_classify u_classify (
        .i_code         (r_code),
        .i_last         (r_last),
        .i_counts       (r_counts),
        .i_min_required (r_min_required),
        .i_variant_only (r_variant_only),
        .o_counts       (n_counts),
        .o_result       (w_result)
    );

    // Only a site-closing base needs the result register.
    assign w_out_blocked = r_out_valid && i_out_stall;
    assign w_advance     = r_in_valid && (!r_last || !w_out_blocked);
    assign w_close       = w_advance && r_last;
    assign o_in_stall    = r_in_valid && !w_advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_code <= i_base_code;
            r_last <= i_last_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_required <= '0;
            r_variant_only <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                asf_pkg::CFG_MIN_REQUIRED: r_min_required <= i_cfg_data;
                asf_pkg::CFG_VARIANT_ONLY: r_variant_only <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_sites_passed  <= '0;
            r_variant_sites <= '0;
            for (int i = 0; i < asf_pkg::NUM_BASES; i++) begin
                r_counts[i]       <= '0;
                r_const_counts[i] <= '0;
            end
        end else begin
            if (w_close) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_advance) begin
                r_counts <= n_counts;
            end
            if (w_close) begin
                if (w_result.inc_site) begin
                    r_sites_passed <= asf_pkg::sat_inc(r_sites_passed);
                end
                if (w_result.inc_variant) begin
                    r_variant_sites <= asf_pkg::sat_inc(r_variant_sites);
                end
                if (w_result.inc_const) begin
                    r_const_counts[w_result.const_base] <=
                        asf_pkg::sat_inc(r_const_counts[w_result.const_base]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_close) begin
            r_status <= w_result.status;
        end
    end

    // Counters move only on a site close, which waits for a free result slot.
    assign o_out_valid     = r_out_valid;
    assign o_site_status   = r_status;
    assign o_site_total    = r_sites_passed[31:0];
    assign o_variant_total = r_variant_sites[31:0];
    assign o_const_a_total = r_const_counts[0][31:0];
    assign o_const_c_total = r_const_counts[1][31:0];
    assign o_const_g_total = r_const_counts[2][31:0];
    assign o_const_t_total = r_const_counts[3][31:0];

    a_counts_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=>
            $stable(r_sites_passed) && $stable(r_variant_sites) && $stable(r_status))
        else $error("counters moved under a stalled result");

    a_variant_within_sites: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_variant_sites <= r_sites_passed)
        else $error("variant count exceeds site count");

    a_variant_result_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == asf_pkg::ST_KEPT_VARIANT |-> r_variant_sites != '0)
        else $error("variant result without variant count");

    a_close_clears_tallies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_close |=> r_counts[0] == '0 && r_counts[1] == '0 &&
                    r_counts[2] == '0 && r_counts[3] == '0)
        else $error("tallies not cleared after site close");

endmodule

>>> bench/alignment_site_filter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the alignment site filter core: random sites, stalls, register sweeps.
module alignment_site_filter_core_tb;

    localparam int CLK_HIGH    = 4;
    localparam int CLK_LOW     = 4;
    localparam int PAUSE_CYC   = 4;
    localparam int DRAIN_CYC   = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_AT     = 700;
    localparam int HOLD_CYC    = 300;
    localparam int PHASE_ITEMS = 250;
    localparam int LONG_SITE   = 60;

    localparam logic [asf_pkg::CODE_W-1:0] CODE_A   = 3'd0;
    localparam logic [asf_pkg::CODE_W-1:0] CODE_C   = 3'd1;
    localparam logic [asf_pkg::CODE_W-1:0] CODE_G   = 3'd2;
    localparam logic [asf_pkg::CODE_W-1:0] CODE_T   = 3'd3;
    localparam logic [asf_pkg::CODE_W-1:0] CODE_N   = 3'd4;
    localparam logic [asf_pkg::CODE_W-1:0] CODE_GAP = 3'd5;
    localparam logic [asf_pkg::CODE_W-1:0] CODE_X6  = 3'd6;
    localparam logic [asf_pkg::CODE_W-1:0] CODE_X7  = 3'd7;

    localparam logic [asf_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'hA5;

    typedef struct packed {
        logic [asf_pkg::CODE_W-1:0] code;
        logic                       last;
    } t_base_item;

    typedef struct packed {
        asf_pkg::t_site_status                                  status;
        asf_pkg::t_count                                        site_total;
        asf_pkg::t_count                                        variant_total;
        logic [asf_pkg::NUM_BASES-1:0][asf_pkg::COUNT_WIDTH-1:0] const_total;
    } t_site_verdict;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_in_valid    = 1'b0;
    logic [asf_pkg::CODE_W-1:0]     i_base_code   = '0;
    logic                           i_last_sample = 1'b0;
    logic                           i_out_stall   = 1'b0;
    logic                           i_cfg_valid   = 1'b0;
    logic [asf_pkg::CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [asf_pkg::CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [1:0]                     o_site_status;
    logic [31:0]                    o_site_total;
    logic [31:0]                    o_variant_total;
    logic [31:0]                    o_const_a_total;
    logic [31:0]                    o_const_c_total;
    logic [31:0]                    o_const_g_total;
    logic [31:0]                    o_const_t_total;
    logic                           o_cfg_ready;

    alignment_site_filter_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_base_code     (i_base_code),
        .i_last_sample   (i_last_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_site_status   (o_site_status),
        .o_site_total    (o_site_total),
        .o_variant_total (o_variant_total),
        .o_const_a_total (o_const_a_total),
        .o_const_c_total (o_const_c_total),
        .o_const_g_total (o_const_g_total),
        .o_const_t_total (o_const_t_total),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Predictor state and register copies
    asf_pkg::t_base_cnt             site_tally [asf_pkg::NUM_BASES];
    logic [asf_pkg::CFG_DATA_W-1:0] min_req_cfg      = '0;
    logic                           variant_only_cfg = 1'b0;
    asf_pkg::t_count                passed_cnt       = '0;
    asf_pkg::t_count                variant_cnt      = '0;
    asf_pkg::t_count                const_cnt [asf_pkg::NUM_BASES];

    t_base_item    pending_q [$];
    t_site_verdict verdict_q [$];

    int  mismatches    = 0;
    int  sites_checked = 0;
    int  accepted_cnt  = 0;
    int  reg_writes    = 0;
    int  cycle_cnt     = 0;
    int  status_seen [4];
    bit  in_taken      = 1'b0;
    bit  hold_on       = 1'b0;
    bit  sender_gaps   = 1'b1;
    int  burst_left    = 1;
    int  gap_left      = 0;
    int  stall_mode    = 0;
    int  stall_span    = 0;
    int  stall_tick    = 0;
    bit  stall_next    = 1'b0;
    t_base_item    cur_item;
    t_site_verdict want;

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    function automatic asf_pkg::t_count bump(input asf_pkg::t_count v);
        return (v == '1) ? v : v + asf_pkg::t_count'(1);
    endfunction

    // Tally one base; on a site end classify the site and queue its verdict.
    task automatic tally_base(input logic [asf_pkg::CODE_W-1:0] code, input logic last);
        int                 total;
        int                 distinct;
        asf_pkg::t_base_idx only_base;
        t_site_verdict      v;
        if (code < asf_pkg::NUM_BASES && site_tally[code[1:0]] != '1) begin
            site_tally[code[1:0]] = site_tally[code[1:0]] + asf_pkg::t_base_cnt'(1);
        end
        if (last) begin
            total     = 0;
            distinct  = 0;
            only_base = '0;
            for (int i = 0; i < asf_pkg::NUM_BASES; i++) begin
                if (site_tally[i] != '0) begin
                    distinct++;
                    only_base = asf_pkg::t_base_idx'(i);
                end
                total += site_tally[i];
            end
            if (total == 0 || total < min_req_cfg) begin
                v.status = asf_pkg::ST_DROP_MISSING;
            end else if (distinct == 1 && variant_only_cfg) begin
                v.status             = asf_pkg::ST_DROP_CONSTANT;
                const_cnt[only_base] = bump(const_cnt[only_base]);
                passed_cnt           = bump(passed_cnt);
            end else begin
                passed_cnt = bump(passed_cnt);
                if (distinct > 1) begin
                    variant_cnt = bump(variant_cnt);
                    v.status    = asf_pkg::ST_KEPT_VARIANT;
                end else begin
                    v.status = asf_pkg::ST_KEPT_CONSTANT;
                end
            end
            for (int i = 0; i < asf_pkg::NUM_BASES; i++) begin
                site_tally[i]     = '0;
                v.const_total[i]  = const_cnt[i];
            end
            v.site_total    = passed_cnt;
            v.variant_total = variant_cnt;
            status_seen[v.status]++;
            verdict_q = {verdict_q, v};
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("site %0d %s: expected %0h, got %0h",
                         sites_checked, name, exp_v, got_v);
            end
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result with no site pending: status %0d", o_site_status);
                end
            end else begin
                want = verdict_q.pop_front();
                check_field("site_status", 32'(want.status), 32'(o_site_status));
                check_field("site_total", want.site_total, o_site_total);
                check_field("variant_total", want.variant_total, o_variant_total);
                check_field("const_a_total", want.const_total[0], o_const_a_total);
                check_field("const_c_total", want.const_total[1], o_const_c_total);
                check_field("const_g_total", want.const_total[2], o_const_g_total);
                check_field("const_t_total", want.const_total[3], o_const_t_total);
                sites_checked++;
            end
        end
        if (in_taken) begin
            accepted_cnt++;
            tally_base(i_base_code, i_last_sample);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d sites outstanding",
                     cycle_cnt, verdict_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // Sender: bursts of transfers separated by random gaps; gaps skipped during hold-off
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (gap_left > 0 && !hold_on) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                cur_item = pending_q.pop_front();
                i_in_valid    <= 1'b1;
                i_base_code   <= cur_item.code;
                i_last_sample <= cur_item.last;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = sender_gaps ? $urandom_range(0, 5) : 0;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches to a random mode whenever its random span runs out
    always @(negedge i_clk) begin
        if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 120);
        end
        stall_span--;
        stall_tick++;
        case (stall_mode)
            0:       stall_next = 1'b0;
            1:       stall_next = ($urandom_range(0, 3) == 0);
            2:       stall_next = ((stall_tick % 5) < 2);
            default: stall_next = ($urandom_range(0, 9) < 7);
        endcase
        i_out_stall <= hold_on || stall_next;
    end

    // Long receiver hold-off so the core backs up into its input
    initial begin
        while (accepted_cnt < HOLD_AT) @(posedge i_clk);
        hold_on = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_on = 1'b0;
    end

    task automatic push_item(input logic [asf_pkg::CODE_W-1:0] code, input logic last);
        t_base_item it;
        it.code = code;
        it.last = last;
        pending_q = {pending_q, it};
    endtask

    task automatic write_reg(input logic [asf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [asf_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            asf_pkg::CFG_MIN_REQUIRED: min_req_cfg      = data;
            asf_pkg::CFG_VARIANT_ONLY: variant_only_cfg = data[0];
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || i_in_valid || verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (PAUSE_CYC) @(posedge i_clk);
    endtask

    // Random site: mostly short, some constant, some all non-ACGT, non-ACGT noise sprinkled in
    task automatic add_random_site(inout int count);
        int                         len;
        int                         kind;
        logic [asf_pkg::CODE_W-1:0] fill;
        logic [asf_pkg::CODE_W-1:0] code;
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        kind = $urandom_range(0, 9);
        fill = asf_pkg::CODE_W'($urandom_range(0, 3));
        for (int k = 0; k < len; k++) begin
            if (kind == 0 || $urandom_range(0, 7) == 0)
                code = asf_pkg::CODE_W'($urandom_range(4, 7));
            else if (kind <= 4)
                code = fill;
            else
                code = asf_pkg::CODE_W'($urandom_range(0, 3));
            push_item(code, k == len - 1);
        end
        count += len;
    endtask

    task automatic run_random(input int target);
        int n;
        n = 0;
        while (n < target) add_random_site(n);
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < asf_pkg::NUM_BASES; i++) begin
            site_tally[i] = '0;
            const_cnt[i]  = '0;
        end
        for (int i = 0; i < 4; i++) status_seen[i] = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, empty and non-ACGT sites, constant and variant
        push_item(CODE_A, 1'b1);
        push_item(CODE_N, 1'b1);
        push_item(CODE_GAP, 1'b0);
        push_item(CODE_X6, 1'b0);
        push_item(CODE_X7, 1'b1);
        push_item(CODE_C, 1'b0);
        push_item(CODE_G, 1'b0);
        push_item(CODE_T, 1'b0);
        push_item(CODE_A, 1'b1);
        push_item(CODE_G, 1'b0);
        push_item(CODE_N, 1'b0);
        push_item(CODE_G, 1'b1);
        wait_idle();

        // Constant drops for each base, then one variant site that is kept
        write_reg(asf_pkg::CFG_MIN_REQUIRED, 11'd1);
        write_reg(asf_pkg::CFG_VARIANT_ONLY, 11'd1);
        write_reg(CFG_SPARE_IDX, 11'h7FF);
        push_item(CODE_T, 1'b1);
        push_item(CODE_A, 1'b1);
        push_item(CODE_C, 1'b1);
        push_item(CODE_G, 1'b1);
        push_item(CODE_X7, 1'b0);
        push_item(CODE_A, 1'b0);
        push_item(CODE_C, 1'b1);
        wait_idle();

        // Minimum boundary: one short of it, then exactly at it
        write_reg(asf_pkg::CFG_MIN_REQUIRED, 11'd3);
        push_item(CODE_A, 1'b0);
        push_item(CODE_A, 1'b1);
        push_item(CODE_C, 1'b0);
        push_item(CODE_X6, 1'b0);
        push_item(CODE_C, 1'b0);
        push_item(CODE_C, 1'b1);
        wait_idle();

        write_reg(asf_pkg::CFG_MIN_REQUIRED, 11'($urandom_range(0, 4)));
        run_random(PHASE_ITEMS);

        write_reg(asf_pkg::CFG_MIN_REQUIRED, 11'd0);
        write_reg(asf_pkg::CFG_VARIANT_ONLY, 11'd0);
        sender_gaps = 1'b0;
        run_random(PHASE_ITEMS);

        sender_gaps = 1'b1;
        write_reg(asf_pkg::CFG_MIN_REQUIRED, 11'($urandom_range(1, 8)));
        write_reg(asf_pkg::CFG_VARIANT_ONLY, 11'd1);
        run_random(PHASE_ITEMS);

        write_reg(asf_pkg::CFG_MIN_REQUIRED, 11'($urandom_range(2, 5)));
        write_reg(asf_pkg::CFG_VARIANT_ONLY, 11'd0);
        run_random(PHASE_ITEMS);

        // Larger sites: exactly at the minimum, then one short with non-ACGT padding
        write_reg(asf_pkg::CFG_MIN_REQUIRED, 11'(LONG_SITE));
        for (int k = 0; k < LONG_SITE; k++) begin
            push_item(asf_pkg::CODE_W'($urandom_range(0, 3)), k == LONG_SITE - 1);
        end
        wait_idle();

        write_reg(asf_pkg::CFG_VARIANT_ONLY, 11'd1);
        for (int k = 0; k < LONG_SITE - 1; k++) begin
            push_item(asf_pkg::CODE_W'($urandom_range(0, 3)), 1'b0);
        end
        push_item(CODE_N, 1'b0);
        push_item(CODE_X7, 1'b0);
        push_item(CODE_GAP, 1'b1);
        wait_idle();

        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("Checked %0d sites from %0d bases under %0d register writes",
                 sites_checked, accepted_cnt, reg_writes);
        $display("Outcomes: %0d missing drops, %0d constant drops, %0d kept constant,",
                 status_seen[0], status_seen[1], status_seen[2]);
        $display("          %0d kept variant", status_seen[3]);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
